>>> hw/rtl/mcku_pkg.sv
// Package for the Morse character keyer: microcode word layout, step codes,
// jump conditions, segment lengths and the character keying table.
// No dependencies; used by every module of the keyer.
`default_nettype none

package mcku_pkg;

	// Character codes
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CODE_FIRST = 8'h30;
	localparam logic [7:0] CODE_LAST  = 8'h5A;
	localparam int         TABLE_LEN  = 43;

	// Segment lengths in dit units
	localparam logic [2:0] UNITS_ZERO = 3'd0;
	localparam logic [2:0] UNITS_DIT  = 3'd1;
	localparam logic [2:0] UNITS_GAP  = 3'd2;
	localparam logic [2:0] UNITS_DAH  = 3'd3;
	localparam logic [2:0] UNITS_WORD = 3'd7;

	// Keying table: pattern in bits 7:3 MSB first (1 = dah), count in bits 2:0
	localparam logic [7:0] KEY_TABLE [0:TABLE_LEN-1] = '{
		8'hFD, 8'h7D, 8'h3D, 8'h1D, 8'h0D,
		8'h05, 8'h85, 8'hC5, 8'hE5, 8'hF5,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h42, 8'h84, 8'hA4, 8'h83, 8'h01, 8'h24,
		8'hC3, 8'h04, 8'h02, 8'h74, 8'hA3, 8'h44,
		8'hC2, 8'h82, 8'hE3, 8'h64, 8'hD4, 8'h43,
		8'h03, 8'h81, 8'h23, 8'h14, 8'h63, 8'h94,
		8'hB4, 8'hC4
	};

	// Microprogram steps
	typedef enum logic [3:0] {
		STEP_WAIT      = 4'd0,
		STEP_CHK_SPACE = 4'd1,
		STEP_CHK_BAD   = 4'd2,
		STEP_SYM_TOP   = 4'd3,
		STEP_MARK      = 4'd4,
		STEP_SYM_GAP   = 4'd5,
		STEP_END_GAP   = 4'd6,
		STEP_WORD      = 4'd7,
		STEP_REJECT    = 4'd8
	} step_t;

	// Jump conditions
	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_START,
		COND_SPACE,
		COND_BAD,
		COND_CNT_ZERO
	} cond_t;

	// Segment length select
	typedef enum logic [2:0] {
		USEL_ZERO,
		USEL_SYM,
		USEL_DIT,
		USEL_GAP,
		USEL_WORD
	} units_sel_t;

	// One control word
	typedef struct packed {
		logic       emit;
		logic       lamp;
		units_sel_t units;
		logic       status;
		logic       last;
		logic       shift;
		logic       dec;
		cond_t      cond;
		step_t      target;
	} ucw_t;

	// Datapath flags seen by the sequencer
	typedef struct packed {
		logic space;
		logic bad;
		logic cnt_zero;
	} seq_flags_t;

	// Microcode ROM
	function automatic ucw_t ucode_word(input step_t step);
		ucw_t w;
		w = '{emit: 1'b0, lamp: 1'b0, units: USEL_ZERO, status: 1'b0, last: 1'b0,
			shift: 1'b0, dec: 1'b0, cond: COND_NEVER, target: STEP_WAIT};
		unique case (step)
			STEP_WAIT: begin
				w.cond   = COND_NO_START;
				w.target = STEP_WAIT;
			end
			STEP_CHK_SPACE: begin
				w.cond   = COND_SPACE;
				w.target = STEP_WORD;
			end
			STEP_CHK_BAD: begin
				w.cond   = COND_BAD;
				w.target = STEP_REJECT;
			end
			STEP_SYM_TOP: begin
				w.cond   = COND_CNT_ZERO;
				w.target = STEP_END_GAP;
			end
			STEP_MARK: begin
				w.emit  = 1'b1;
				w.lamp  = 1'b1;
				w.units = USEL_SYM;
				w.shift = 1'b1;
			end
			STEP_SYM_GAP: begin
				w.emit   = 1'b1;
				w.units  = USEL_DIT;
				w.dec    = 1'b1;
				w.cond   = COND_ALWAYS;
				w.target = STEP_SYM_TOP;
			end
			STEP_END_GAP: begin
				w.emit   = 1'b1;
				w.units  = USEL_GAP;
				w.last   = 1'b1;
				w.cond   = COND_ALWAYS;
				w.target = STEP_WAIT;
			end
			STEP_WORD: begin
				w.emit   = 1'b1;
				w.units  = USEL_WORD;
				w.last   = 1'b1;
				w.cond   = COND_ALWAYS;
				w.target = STEP_WAIT;
			end
			STEP_REJECT: begin
				w.emit   = 1'b1;
				w.units  = USEL_ZERO;
				w.status = 1'b1;
				w.last   = 1'b1;
				w.cond   = COND_ALWAYS;
				w.target = STEP_WAIT;
			end
			default: begin
				w.cond   = COND_ALWAYS;
				w.target = STEP_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mcku_sequencer.sv
// Microcode sequencer of the Morse keyer: step counter, control ROM fetch
// and conditional jumps. Depends on mcku_pkg.
`default_nettype none

module mcku_sequencer (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  mcku_pkg::seq_flags_t flags,
	output mcku_pkg::ucw_t      ctrl,
	output logic                busy
);
	import mcku_pkg::*;

	step_t upc_q;
	step_t upc_next;
	logic  take_jump;

	// control word of the current step
	assign ctrl = ucode_word(upc_q);
	assign busy = (upc_q != STEP_WAIT);

	// jump condition select
	always_comb begin
		case (ctrl.cond)
			COND_NEVER:    take_jump = 1'b0;
			COND_ALWAYS:   take_jump = 1'b1;
			COND_NO_START: take_jump = !start;
			COND_SPACE:    take_jump = flags.space;
			COND_BAD:      take_jump = flags.bad;
			COND_CNT_ZERO: take_jump = flags.cnt_zero;
			default:       take_jump = 1'b1;
		endcase
	end

	// next step
	always_comb begin
		if (take_jump) begin
			upc_next = ctrl.target;
		end else begin
			upc_next = step_t'(upc_q + 4'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= STEP_WAIT;
		end else begin
			upc_q <= upc_next;
		end
	end

`ifndef ASSERT_OFF
	// step counter never leaves the program
	a_upc_range: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q <= STEP_REJECT)
		else $error("step counter outside microprogram");

	// a transfer starts the decode
	a_accept_step: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (upc_q == STEP_CHK_SPACE))
		else $error("accepted character did not enter decode");

	// the closing gap returns to wait
	a_end_return: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == STEP_END_GAP) |=> !busy)
		else $error("sequencer did not return after final gap");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/mcku_datapath.sv
// Datapath of the Morse keyer: character decode and table lookup, symbol
// pattern shift register, symbol counter and result registers.
// Depends on mcku_pkg.
`default_nettype none

module mcku_datapath (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  load,
	input  wire  [7:0]           character,
	input  mcku_pkg::ucw_t       ctrl,
	output mcku_pkg::seq_flags_t flags,
	output logic                 strobe,
	output logic                 lamp_on,
	output logic [2:0]           duration_units,
	output logic                 status,
	output logic                 last
);
	import mcku_pkg::*;

	logic [7:0] idx_full;
	logic [5:0] idx;
	logic       in_range;
	logic [7:0] code;
	logic [4:0] pattern_q;
	logic [2:0] count_q;
	logic       space_q;
	logic       bad_q;
	logic [2:0] units;
	logic       strobe_q;
	logic       lamp_q;
	logic [2:0] units_q;
	logic       status_q;
	logic       last_q;

	// table lookup of the incoming character
	assign in_range = (character >= CODE_FIRST) && (character <= CODE_LAST);
	assign idx_full = character - CODE_FIRST;
	assign idx      = idx_full[5:0];
	assign code     = in_range ? KEY_TABLE[idx] : 8'h00;

	// character registers
	always_ff @(posedge clk) begin
		if (load) begin
			space_q   <= (character == CHAR_SPACE);
			bad_q     <= !in_range && (character != CHAR_SPACE);
			pattern_q <= code[7:3];
			count_q   <= code[2:0];
		end else begin
			if (ctrl.shift) begin
				pattern_q <= {pattern_q[3:0], 1'b0};
			end
			if (ctrl.dec) begin
				count_q <= count_q - 3'd1;
			end
		end
	end

	assign flags = '{space: space_q, bad: bad_q, cnt_zero: (count_q == 3'd0)};

	// segment length select
	always_comb begin
		case (ctrl.units)
			USEL_ZERO: units = UNITS_ZERO;
			USEL_SYM:  units = pattern_q[4] ? UNITS_DAH : UNITS_DIT;
			USEL_DIT:  units = UNITS_DIT;
			USEL_GAP:  units = UNITS_GAP;
			USEL_WORD: units = UNITS_WORD;
			default:   units = UNITS_ZERO;
		endcase
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= ctrl.emit;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			lamp_q   <= ctrl.lamp;
			units_q  <= units;
			status_q <= ctrl.status;
			last_q   <= ctrl.last;
		end
	end

	assign strobe         = strobe_q;
	assign lamp_on        = lamp_q;
	assign duration_units = units_q;
	assign status         = status_q;
	assign last           = last_q;

`ifndef ASSERT_OFF
	// a rejected character is one zero-length final segment
	a_reject_form: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && status_q) |-> (last_q && !lamp_q && (units_q == UNITS_ZERO)))
		else $error("malformed reject segment");

	// symbols are only emitted while some remain
	a_shift_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.shift |-> (count_q != 3'd0))
		else $error("symbol emitted with zero count");

	// a lit segment is always followed by its dark dit
	a_lit_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.emit && ctrl.lamp) |=> (ctrl.emit && ctrl.dec))
		else $error("lit segment without trailing dit gap");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/morse_character_keyer_unit.sv
// One segment is strobed per mark/gap step: a space gives one word gap, a rejected
// byte one zero-length segment with status set, a table character a mark and a
// dit gap per symbol and then a closing gap. busy stays high until the microcode
// is back at its wait step, so no new character is taken before the last is done.
// Reset clears the step counter and the result strobe; the receiver cannot stall.
// Top level of the Morse keyer; depends on mcku_pkg, mcku_sequencer, mcku_datapath.
`default_nettype none

module morse_character_keyer_unit (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	output logic       busy,
	input  wire  [7:0] character,
	output logic       strobe,
	output logic       lamp_on,
	output logic [2:0] duration_units,
	output logic       status,
	output logic       last
);
	import mcku_pkg::*;

	ucw_t       ctrl;
	seq_flags_t flags;
	logic       load;

	// transfer of a character
	assign load = start && !busy;

	mcku_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	mcku_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (load),
		.character      (character),
		.ctrl           (ctrl),
		.flags          (flags),
		.strobe         (strobe),
		.lamp_on        (lamp_on),
		.duration_units (duration_units),
		.status         (status),
		.last           (last)
	);

endmodule

`default_nettype wire

>>> verif/morse_character_keyer_unit_test.sv
// Self-checking testbench for morse_character_keyer_unit: drives character transfers
// and checks every keying segment against a predictor built into a small scoreboard.
// Depends on mcku_pkg and the keyer RTL only.

module morse_character_keyer_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mcku_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 60000;
	localparam int unsigned RANDOM_CHARS  = 147;
	localparam int unsigned QUIET_TAIL    = 30;
	localparam int unsigned DRAIN_CYCLES  = 30;

	// Morse patterns for '0'..'Z': bits 7:3 symbols MSB first (1 = dah), bits 2:0 count
	localparam logic [7:0] MORSE_CODES [0:42] = '{
		8'hFD, 8'h7D, 8'h3D, 8'h1D, 8'h0D,
		8'h05, 8'h85, 8'hC5, 8'hE5, 8'hF5,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h42, 8'h84, 8'hA4, 8'h83, 8'h01, 8'h24,
		8'hC3, 8'h04, 8'h02, 8'h74, 8'hA3, 8'h44,
		8'hC2, 8'h82, 8'hE3, 8'h64, 8'hD4, 8'h43,
		8'h03, 8'h81, 8'h23, 8'h14, 8'h63, 8'h94,
		8'hB4, 8'hC4
	};

	typedef struct packed {
		logic       lamp;
		logic [2:0] units;
		logic       status;
		logic       last;
	} segment_t;

	// Predicts the keying run of each character and checks segments in order
	class keying_scoreboard;
		segment_t    pending[$];
		int unsigned mismatches;
		int unsigned segments_seen;
		int unsigned chars_noted;

		function new();
			mismatches    = 0;
			segments_seen = 0;
			chars_noted   = 0;
		endfunction

		function void push_segment(logic lamp, logic [2:0] units, logic status, logic last);
			segment_t s;
			s.lamp   = lamp;
			s.units  = units;
			s.status = status;
			s.last   = last;
			pending.push_back(s);
		endfunction

		function void note_character(logic [7:0] ch);
			logic [7:0] code;
			int         n;
			chars_noted++;
			if (ch == CHAR_SPACE) begin
				push_segment(1'b0, UNITS_WORD, 1'b0, 1'b1);
			end else if (ch < CODE_FIRST || ch > CODE_LAST) begin
				push_segment(1'b0, UNITS_ZERO, 1'b1, 1'b1);
			end else begin
				code = MORSE_CODES[ch - CODE_FIRST];
				// mark then one-dit space per symbol, dahs from the top bit
				for (n = int'(code[2:0]); n > 0; n--) begin
					push_segment(1'b1, code[7] ? UNITS_DAH : UNITS_DIT, 1'b0, 1'b0);
					push_segment(1'b0, UNITS_DIT, 1'b0, 1'b0);
					code = code << 1;
				end
				// closing gap; empty codes give only this
				push_segment(1'b0, UNITS_GAP, 1'b0, 1'b1);
			end
		endfunction

		function void check_segment(logic lamp, logic [2:0] units, logic status, logic last);
			segment_t want;
			segments_seen++;
			if (pending.size() == 0) begin
				$error("unexpected segment: lamp_on=%0d duration_units=%0d status=%0d last=%0d",
					lamp, units, status, last);
				mismatches++;
				return;
			end
			want = pending.pop_front();
			if (lamp !== want.lamp) begin
				$error("lamp_on: expected %0d, got %0d", want.lamp, lamp);
				mismatches++;
			end
			if (units !== want.units) begin
				$error("duration_units: expected %0d, got %0d", want.units, units);
				mismatches++;
			end
			if (status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, status);
				mismatches++;
			end
			if (last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, last);
				mismatches++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic [7:0] character = 8'h00;
	logic       busy;
	logic       strobe;
	logic       lamp_on;
	logic [2:0] duration_units;
	logic       status;
	logic       last;

	keying_scoreboard board;
	int unsigned      cycle_count = 0;

	morse_character_keyer_unit uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.character      (character),
		.strobe         (strobe),
		.lamp_on        (lamp_on),
		.duration_units (duration_units),
		.status         (status),
		.last           (last)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d segments outstanding",
				cycle_count, board.pending.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Segment monitor: every strobe is a transfer the receiver must take
	always @(posedge clk) begin
		if (arst_n && strobe)
			board.check_segment(lamp_on, duration_units, status, last);
	end

	// One character transfer, with an optional idle burst ahead of it
	task automatic send_character(input logic [7:0] ch, input bit allow_idle);
		int gap;
		if (allow_idle && $urandom_range(0, 2) == 0) begin
			start = 1'b0;
			gap = $urandom_range(1, 14);
			repeat (gap) @(negedge clk);
		end
		start     = 1'b1;
		character = ch;
		do @(posedge clk); while (busy);
		board.note_character(ch);
		@(negedge clk);
	endtask

	initial begin
		logic [7:0] directed [$];
		logic [7:0] ch;
		int         pick;
		board = new();

		// Reset held low from time zero, released on a falling edge
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: space, empty codes, range edges, all-dit / all-dah, rejects
		directed = '{8'h20, 8'h3A, 8'h40, 8'h30, 8'h39, 8'h35, 8'h41, 8'h45,
			8'h54, 8'h5A, 8'h51, 8'h2F, 8'h5B, 8'h61, 8'h00, 8'hFF,
			8'h7F, 8'h80, 8'h55, 8'hAA, 8'h20, 8'h20, 8'h3F};
		foreach (directed[i])
			send_character(directed[i], 1'b1);

		// Random: mostly table characters, some spaces, some arbitrary bytes
		for (int i = 0; i < RANDOM_CHARS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 65)
				ch = 8'($urandom_range(CODE_FIRST, CODE_LAST));
			else if (pick < 75)
				ch = CHAR_SPACE;
			else
				ch = 8'($urandom_range(0, 255));
			send_character(ch, i < RANDOM_CHARS - QUIET_TAIL);
		end
		start = 1'b0;

		// Drain, then allow for any trailing segment
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.pending.size() != 0) begin
			$error("%0d expected segments never arrived", board.pending.size());
			board.mismatches++;
		end

		$display("%0d characters keyed (directed edges, spaces, empty codes, rejects, random)",
			board.chars_noted);
		$display("%0d segments compared, %0d field mismatches",
			board.segments_seen, board.mismatches);
		if (board.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> morse_character_keyer_unit.f
hw/rtl/mcku_pkg.sv
hw/rtl/mcku_sequencer.sv
hw/rtl/mcku_datapath.sv
hw/rtl/morse_character_keyer_unit.sv
verif/morse_character_keyer_unit_test.sv
